// ===== hw/rtl/atqr_pkg.sv =====
// ----------------------------------------------------------------------------
// atqr_pkg
// Types and constants shared by the region query block.
// ----------------------------------------------------------------------------
package atqr_pkg;

   localparam int CoordBits  = 32;
   localparam int ResultCap  = 64;
   localparam logic signed [31:0] TOne    = 32'sh4000_0000;
   localparam logic signed [31:0] TSatMax = 32'sh7fff_ffff;
   localparam logic signed [31:0] TSatMin = 32'sh8000_0000;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_RECT = 2'd1;
   localparam logic [1:0] FUNC_SEG  = 2'd2;

   typedef struct packed {
      logic signed [CoordBits-1:0] lo_x;
      logic signed [CoordBits-1:0] lo_z;
      logic signed [CoordBits-1:0] hi_x;
      logic signed [CoordBits-1:0] hi_z;
      logic                        leaf;
      logic [7:0]                  span;
   } node_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EVAL, ST_SEGW, ST_STEP, ST_FINISH
   } walk_state_type;

   typedef enum logic [1:0] {
      SG_IDLE, SG_AXIS, SG_DIV
   } seg_state_type;

endpackage

// ===== hw/rtl/atqr_if.sv =====
// ----------------------------------------------------------------------------
// atqr channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface atqr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [6:0]         node_slot;
   logic signed [31:0] box_lo_x;
   logic signed [31:0] box_lo_z;
   logic signed [31:0] box_hi_x;
   logic signed [31:0] box_hi_z;
   logic               is_leaf;
   logic [7:0]         subtree_span;
   logic signed [31:0] query_ax;
   logic signed [31:0] query_az;
   logic signed [31:0] query_bx;
   logic signed [31:0] query_bz;
   modport source (output valid, func, node_slot, box_lo_x, box_lo_z, box_hi_x,
                   box_hi_z, is_leaf, subtree_span, query_ax, query_az, query_bx,
                   query_bz, input ready);
   modport sink (input valid, func, node_slot, box_lo_x, box_lo_z, box_hi_x,
                 box_hi_z, is_leaf, subtree_span, query_ax, query_az, query_bx,
                 query_bz, output ready);
endinterface

interface atqr_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] leaf_index;
   logic       hit;
   logic       final_hit;
   modport source (output valid, leaf_index, hit, final_hit, input ready);
   modport sink (input valid, leaf_index, hit, final_hit, output ready);
endinterface

interface atqr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] node_count;
   modport source (output valid, node_count, input ready);
   modport sink (input valid, node_count, output ready);
endinterface

// ===== hw/rtl/atqr_node_mem.sv =====
// ----------------------------------------------------------------------------
// atqr_node_mem
// Node store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module atqr_node_mem #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  atqr_pkg::node_type       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output atqr_pkg::node_type       rd_data
);
   import atqr_pkg::*;

   node_type mem [DEPTH];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/atqr_slab_div.sv =====
// ----------------------------------------------------------------------------
// atqr_slab_div
// Bit-serial divider for t = num * 2^30 / den, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
module atqr_slab_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] num,
   input  logic signed [32:0] den,
   output logic               done,
   output logic signed [31:0] t
);
   import atqr_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [32:0]        rem_ff, rem_in;
   logic [32:0]        dabs_ff, dabs_in;
   logic [31:0]        sh_ff, sh_in;
   logic [31:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic [32:0]        nabs;
   logic [32:0]        dabs;
   logic [33:0]        trial;
   logic               ge;

   always_comb begin
      nabs    = num[32] ? 33'(-num) : 33'(num);
      dabs    = den[32] ? 33'(-den) : 33'(den);
      trial   = {rem_ff, sh_ff[31]};
      ge      = trial >= {1'b0, dabs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dabs_in = dabs_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {2'b00, nabs[32:2]};
         sh_in   = {nabs[1:0], 30'd0};
         dabs_in = dabs;
         quo_in  = '0;
         neg_in  = num[32] ^ den[32];
         ovf_in  = {2'b00, nabs} >= {dabs, 2'b00};
      end else if (busy_ff) begin
         rem_in = ge ? 33'(trial - {1'b0, dabs_ff}) : trial[32:0];
         quo_in = {quo_ff[30:0], ge};
         sh_in  = {sh_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dabs_ff <= dabs_in;
      sh_ff   <= sh_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
   end

   always_comb begin
      if (ovf_ff) begin
         t = neg_ff ? TSatMin : TSatMax;
      end else if (neg_ff) begin
         t = (quo_ff > 32'h8000_0000) ? TSatMin : 32'(-quo_ff);
      end else begin
         t = quo_ff[31] ? TSatMax : $signed(quo_ff);
      end
   end

   assign done = done_ff;

endmodule

// ===== hw/rtl/atqr_seg_test.sv =====
// ----------------------------------------------------------------------------
// atqr_seg_test
// Slab test of a segment against one node box, one axis after the other.
// ----------------------------------------------------------------------------
module atqr_seg_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] p_x,
   input  logic signed [31:0] p_z,
   input  logic signed [31:0] q_x,
   input  logic signed [31:0] q_z,
   input  atqr_pkg::node_type box,
   output logic               done,
   output logic               hit
);
   import atqr_pkg::*;

   seg_state_type      state_ff, state_in;
   logic               axis_ff, axis_in;
   logic signed [31:0] tmin_ff, tmin_in;
   logic signed [31:0] tmax_ff, tmax_in;
   logic               done_ff, done_in;
   logic               hit_ff, hit_in;
   logic signed [31:0] p, q, lo, hi;
   logic signed [32:0] d, n_lo, n_hi;
   logic               div_start;
   logic               div_done;
   logic               div_done_b;
   logic signed [31:0] t_a, t_b, t1, t2, nmin, nmax;

   always_comb begin
      p    = axis_ff ? p_z : p_x;
      q    = axis_ff ? q_z : q_x;
      lo   = axis_ff ? box.lo_z : box.lo_x;
      hi   = axis_ff ? box.hi_z : box.hi_x;
      d    = {q[31], q} - {p[31], p};
      n_lo = {lo[31], lo} - {p[31], p};
      n_hi = {hi[31], hi} - {p[31], p};
   end

   atqr_slab_div u_div_lo (
      .clock (clock), .reset (reset), .start (div_start),
      .num (n_lo), .den (d), .done (div_done), .t (t_a)
   );

   atqr_slab_div u_div_hi (
      .clock (clock), .reset (reset), .start (div_start),
      .num (n_hi), .den (d), .done (div_done_b), .t (t_b)
   );

   always_comb begin
      t1   = (t_a > t_b) ? t_b : t_a;
      t2   = (t_a > t_b) ? t_a : t_b;
      nmin = (t1 > tmin_ff) ? t1 : tmin_ff;
      nmax = (t2 < tmax_ff) ? t2 : tmax_ff;
      state_in  = state_ff;
      axis_in   = axis_ff;
      tmin_in   = tmin_ff;
      tmax_in   = tmax_ff;
      done_in   = 1'b0;
      hit_in    = hit_ff;
      div_start = 1'b0;
      case (state_ff)
         SG_IDLE: begin
            if (start) begin
               axis_in  = 1'b0;
               tmin_in  = '0;
               tmax_in  = TOne;
               state_in = SG_AXIS;
            end
         end
         SG_AXIS: begin
            if (d == '0) begin
               if (p < lo || p > hi) begin
                  done_in  = 1'b1;
                  hit_in   = 1'b0;
                  state_in = SG_IDLE;
               end else if (axis_ff) begin
                  done_in  = 1'b1;
                  hit_in   = 1'b1;
                  state_in = SG_IDLE;
               end else begin
                  axis_in = 1'b1;
               end
            end else begin
               div_start = 1'b1;
               state_in  = SG_DIV;
            end
         end
         SG_DIV: begin
            if (div_done) begin
               tmin_in = nmin;
               tmax_in = nmax;
               if (nmin > nmax) begin
                  done_in  = 1'b1;
                  hit_in   = 1'b0;
                  state_in = SG_IDLE;
               end else if (axis_ff) begin
                  done_in  = 1'b1;
                  hit_in   = 1'b1;
                  state_in = SG_IDLE;
               end else begin
                  axis_in  = 1'b1;
                  state_in = SG_AXIS;
               end
            end
         end
         default: state_in = SG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      axis_ff <= axis_in;
      tmin_ff <= tmin_in;
      tmax_ff <= tmax_in;
      hit_ff  <= hit_in;
   end

   assign done = done_ff;
   assign hit  = hit_ff;

   a_div_pair: assert property (@(posedge clock) disable iff (reset)
      div_done == div_done_b) else $error("slab dividers out of step");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == SG_DIV) else $error("divider done outside wait");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == SG_IDLE) else $error("done while busy");

endmodule

// ===== hw/rtl/aabb_tree_region_query.sv =====
// ----------------------------------------------------------------------------
// aabb_tree_region_query
// Walks a preorder box tree held in node memory, reports overlapping leaves.
// ----------------------------------------------------------------------------
// Load requests write one node slot. A query walks the tree, skipping subtrees
// that miss; a segment test uses two bit-serial dividers per axis, and output
// stalls hold the walk. One transaction at a time; the result register lets
// the next transaction in while the last result waits.
// Reset clears control and node_count; node memory is undefined until loaded.
module aabb_tree_region_query #(
   parameter int MAX_NODES = 128
) (
   input logic       clock,
   input logic       reset,
   atqr_req_if.sink  req_bus,
   atqr_rsp_if.source rsp_bus,
   atqr_csr_if.sink  csr_bus
);
   import atqr_pkg::*;

   localparam int AW = $clog2(MAX_NODES);

   walk_state_type     state_ff, state_in;
   logic [7:0]         node_count_ff;
   logic [7:0]         limit_ff, limit_in;
   logic [8:0]         idx_ff, idx_in;
   logic [6:0]         count_ff, count_in;
   logic               pend_ff, pend_in;
   logic [6:0]         pend_idx_ff, pend_idx_in;
   logic               ov_ff, ov_in;
   logic               seg_ff, seg_in;
   logic signed [31:0] ax_ff, az_ff, bx_ff, bz_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_final_ff, rsp_final_in;
   logic               req_acc;
   logic               is_query;
   logic               out_busy;
   logic               wr_en;
   node_type           wr_data;
   logic               rd_en;
   node_type           rd_data;
   logic               rect_ov;
   logic               seg_start;
   logic               seg_done;
   logic               seg_hit;
   logic               hit_now;

   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_bus.valid) begin
         node_count_ff <= csr_bus.node_count;
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign is_query = (req_bus.func == FUNC_RECT) || (req_bus.func == FUNC_SEG);
   assign wr_en    = req_acc && (req_bus.func == FUNC_LOAD)
                     && (32'(req_bus.node_slot) < 32'(MAX_NODES));
   assign wr_data  = '{lo_x: req_bus.box_lo_x, lo_z: req_bus.box_lo_z,
                       hi_x: req_bus.box_hi_x, hi_z: req_bus.box_hi_z,
                       leaf: req_bus.is_leaf, span: req_bus.subtree_span};

   atqr_node_mem #(.DEPTH (MAX_NODES)) u_mem (
      .clock (clock), .wr_en (wr_en), .wr_addr (AW'(req_bus.node_slot)),
      .wr_data (wr_data), .rd_en (rd_en), .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   atqr_seg_test u_seg (
      .clock (clock), .reset (reset), .start (seg_start),
      .p_x (ax_ff), .p_z (az_ff), .q_x (bx_ff), .q_z (bz_ff),
      .box (rd_data), .done (seg_done), .hit (seg_hit)
   );

   assign rect_ov = (ax_ff <= rd_data.hi_x) && (bx_ff >= rd_data.lo_x)
                    && (az_ff <= rd_data.hi_z) && (bz_ff >= rd_data.lo_z);
   assign out_busy = rsp_valid_ff && !rsp_bus.ready;
   assign hit_now  = rd_data.leaf && ov_ff;

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      ov_in        = ov_ff;
      seg_in       = seg_ff;
      rd_en        = 1'b0;
      seg_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_final_in = rsp_final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_query) begin
               idx_in   = '0;
               count_in = '0;
               pend_in  = 1'b0;
               seg_in   = (req_bus.func == FUNC_SEG);
               limit_in = (32'(node_count_ff) < 32'(MAX_NODES))
                          ? node_count_ff : 8'(MAX_NODES);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (idx_ff < {1'b0, limit_ff} && count_ff < 7'(ResultCap)) begin
               rd_en    = 1'b1;
               state_in = ST_EVAL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EVAL: begin
            if (seg_ff) begin
               seg_start = 1'b1;
               state_in  = ST_SEGW;
            end else begin
               ov_in    = rect_ov;
               state_in = ST_STEP;
            end
         end
         ST_SEGW: begin
            if (seg_done) begin
               ov_in    = seg_hit;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!(hit_now && pend_ff && out_busy)) begin
               if (hit_now && pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = pend_idx_ff;
                  rsp_hit_in   = 1'b1;
                  rsp_final_in = 1'b0;
               end
               if (hit_now) begin
                  pend_in     = 1'b1;
                  pend_idx_in = idx_ff[6:0];
                  count_in    = count_ff + 7'd1;
               end
               if (ov_ff || rd_data.leaf || rd_data.span == '0) begin
                  idx_in = idx_ff + 9'd1;
               end else begin
                  idx_in = idx_ff + {1'b0, rd_data.span};
               end
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = pend_ff ? pend_idx_ff : '0;
               rsp_hit_in   = pend_ff;
               rsp_final_in = 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      limit_ff     <= limit_in;
      idx_ff       <= idx_in;
      count_ff     <= count_in;
      pend_idx_ff  <= pend_idx_in;
      ov_ff        <= ov_in;
      seg_ff       <= seg_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_final_ff <= rsp_final_in;
      if (req_acc && is_query) begin
         ax_ff <= req_bus.query_ax;
         az_ff <= req_bus.query_az;
         bx_ff <= req_bus.query_bx;
         bz_ff <= req_bus.query_bz;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.leaf_index = rsp_idx_ff;
   assign rsp_bus.hit        = rsp_hit_ff;
   assign rsp_bus.final_hit  = rsp_final_ff;

   a_empty_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_final_ff) else $error("empty not final");
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> idx_ff < {1'b0, limit_ff}) else $error("read past node limit");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(ResultCap)) else $error("result cap exceeded");
   a_segw: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEGW |-> seg_ff) else $error("segment wait on rectangle query");

endmodule
